// ----- rtl/osp_pkg.sv -----
// shared types, codes and field widths for the ordered slot pool allocator
package osp_pkg;

  // default pool size
  localparam int SLOTS_DEF = 32;

  // fixed field widths of the request and result channels
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;

  // request command codes, code 3 is served as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_AL_LINK,
    S_AL_TAIL,
    S_FR_WALK,
    S_FR_NEXT,
    S_FR_DEC,
    S_FR_PUSH,
    S_FR_TAIL,
    S_QR_WAIT,
    S_DONE
  } state_t;

endpackage

// ----- rtl/osp_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
module osp_ram import osp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds the last word when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/osp_link_tbl.sv -----
// link table: ram plus per-entry written flags, unwritten entries read as the initial free chain
module osp_link_tbl import osp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(SLOTS)-1:0]     wr_addr,
  input  logic [$clog2(SLOTS+1)-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr,
  output logic [$clog2(SLOTS+1)-1:0]   rd_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS+1);

  logic [SLOTS-1:0] written_r;
  logic             rd_written_r;
  logic [IW-1:0]    rd_addr_r;
  logic [PW-1:0]    ram_q;

  osp_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  // read side bookkeeping, aligned with the ram output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r    <= rd_addr;
      rd_written_r <= written_r[rd_addr];
    end
  end

  // an entry never written points to the next slot, the last one to null
  assign rd_data = rd_written_r ? ram_q : (PW'(rd_addr_r) + PW'(1));

endmodule

// ----- rtl/ordered_slot_pool_allocator.sv -----
// top level: slot pool sequencer with link and position tables
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------
//  in      | in_command, in_slot                     | in_valid / in_stall
//  out     | out_status, out_result_slot,            | out_valid / out_stall
//          | out_position_number, out_active_count,  |
//          | out_first_valid, out_first_slot         |
//
// one request at a time. an allocate also links the old active tail when the
// active list is not empty; a query of an active slot reads the position table;
// a full pool, a free of an inactive slot or a query of a free slot go straight
// to the result load. a free walks the active list one hop per cycle through
// the single link table read port and the position table decrement, then joins
// the free list. the next request is taken in the cycle after the result load.
// reset is synchronous and needs no clearing pass; per-entry written flags
// stand in for the initial free chain. a held result does not block the next
// request, only its completion waits for the output register to empty.
module ordered_slot_pool_allocator import osp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SLOT_W-1:0] in_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [SLOT_W-1:0] out_result_slot,
  output logic [POS_W-1:0]  out_position_number,
  output logic [POS_W-1:0]  out_active_count,
  output logic              out_first_valid,
  output logic [SLOT_W-1:0] out_first_slot
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS+1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // sequencer and list state
  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [PW-1:0]     cur_r, cur_nxt;
  logic [PW-1:0]     prev_r, prev_nxt;
  logic [PW-1:0]     fh_r, fh_nxt;
  logic [PW-1:0]     ft_r, ft_nxt;
  logic [PW-1:0]     ah_r, ah_nxt;
  logic [PW-1:0]     at_r, at_nxt;
  logic [PW-1:0]     live_r, live_nxt;
  logic [SLOTS-1:0]  in_use_r, in_use_nxt;
  status_t           stat_r, stat_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;

  // result register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_result_slot_r;
  logic [POS_W-1:0]  out_position_number_r;
  logic [POS_W-1:0]  out_active_count_r;
  logic              out_first_valid_r;
  logic [SLOT_W-1:0] out_first_slot_r;
  logic              out_load;

  // table ports
  logic          lnk_we, lnk_re;
  logic [IW-1:0] lnk_waddr, lnk_raddr;
  logic [PW-1:0] lnk_wdata, lnk_q;
  logic          rnk_we, rnk_re;
  logic [IW-1:0] rnk_waddr, rnk_raddr;
  logic [PW-1:0] rnk_wdata, rnk_q;

  // decoded request
  logic          accept;
  logic          slot_ok;
  logic [IW-1:0] s_idx;
  logic [PW-1:0] s_ptr;

  assign accept  = in_valid && !in_stall;
  assign slot_ok = 32'(slot_r) < 32'(SLOTS);
  assign s_idx   = IW'(slot_r);
  assign s_ptr   = PW'(slot_r);

  osp_link_tbl #(
    .SLOTS (SLOTS)
  ) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lnk_we),
    .wr_addr (lnk_waddr),
    .wr_data (lnk_wdata),
    .rd_en   (lnk_re),
    .rd_addr (lnk_raddr),
    .rd_data (lnk_q)
  );

  osp_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_rank (
    .clk   (clk),
    .we    (rnk_we),
    .waddr (rnk_waddr),
    .wdata (rnk_wdata),
    .re    (rnk_re),
    .raddr (rnk_raddr),
    .rdata (rnk_q)
  );

  // state and list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fh_r     <= '0;
      ft_r     <= PW'(SLOTS - 1);
      ah_r     <= NIL;
      at_r     <= NIL;
      live_r   <= '0;
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fh_r     <= fh_nxt;
      ft_r     <= ft_nxt;
      ah_r     <= ah_nxt;
      at_r     <= at_nxt;
      live_r   <= live_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      slot_r <= in_slot;
    end
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    stat_r  <= stat_nxt;
    rslot_r <= rslot_nxt;
    pos_r   <= pos_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    fh_nxt     = fh_r;
    ft_nxt     = ft_r;
    ah_nxt     = ah_r;
    at_nxt     = at_r;
    live_nxt   = live_r;
    in_use_nxt = in_use_r;
    stat_nxt   = stat_r;
    rslot_nxt  = rslot_r;
    pos_nxt    = pos_r;
    lnk_we     = 1'b0;
    lnk_waddr  = IW'(cur_r);
    lnk_wdata  = NIL;
    lnk_re     = 1'b0;
    lnk_raddr  = IW'(cur_r);
    rnk_we     = 1'b0;
    rnk_waddr  = IW'(cur_r);
    rnk_wdata  = rnk_q - PW'(rnk_q != '0);
    rnk_re     = 1'b0;
    rnk_raddr  = IW'(cur_r);
    out_load   = 1'b0;
    in_stall   = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      // classify the request and start its first table access
      S_DECODE: begin
        stat_nxt  = STAT_OK;
        rslot_nxt = slot_r;
        pos_nxt   = '0;
        case (cmd_r)
          CMD_ALLOC: begin
            rslot_nxt = '0;
            if (fh_r == NIL) begin
              stat_nxt  = STAT_FULL;
              state_nxt = S_DONE;
            end else begin
              cur_nxt   = fh_r;
              lnk_re    = 1'b1;
              lnk_raddr = IW'(fh_r);
              state_nxt = S_AL_LINK;
            end
          end
          CMD_FREE: begin
            if (!slot_ok || !in_use_r[s_idx]) begin
              stat_nxt  = STAT_NOT_ACTIVE;
              state_nxt = S_DONE;
            end else begin
              prev_nxt  = NIL;
              cur_nxt   = ah_r;
              state_nxt = S_FR_WALK;
            end
          end
          default: begin
            if (slot_ok && in_use_r[s_idx]) begin
              rnk_re    = 1'b1;
              rnk_raddr = s_idx;
              state_nxt = S_QR_WAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end

      // free head taken: advance free list, append to active list
      S_AL_LINK: begin
        fh_nxt = lnk_q;
        if (lnk_q == NIL) begin
          ft_nxt = NIL;
        end
        lnk_we                 = 1'b1;
        lnk_waddr              = IW'(cur_r);
        lnk_wdata              = NIL;
        rnk_we                 = 1'b1;
        rnk_waddr              = IW'(cur_r);
        rnk_wdata              = live_r + PW'(1);
        in_use_nxt[IW'(cur_r)] = 1'b1;
        live_nxt               = live_r + PW'(1);
        rslot_nxt              = SLOT_W'(cur_r);
        pos_nxt                = live_r + PW'(1);
        if (ah_r == NIL) begin
          ah_nxt    = cur_r;
          at_nxt    = cur_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_AL_TAIL;
        end
      end

      // old active tail points to the new slot
      S_AL_TAIL: begin
        lnk_we    = 1'b1;
        lnk_waddr = IW'(at_r);
        lnk_wdata = cur_r;
        at_nxt    = cur_r;
        state_nxt = S_DONE;
      end

      // start the walk at the active head
      S_FR_WALK: begin
        lnk_re    = 1'b1;
        lnk_raddr = IW'(cur_r);
        state_nxt = S_FR_NEXT;
      end

      // one hop a cycle until the slot is reached, then unlink it
      S_FR_NEXT: begin
        if (cur_r == s_ptr) begin
          if (prev_r == NIL) begin
            ah_nxt = lnk_q;
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = IW'(prev_r);
            lnk_wdata = lnk_q;
          end
          if (at_r == s_ptr) begin
            at_nxt = prev_r;
          end
          cur_nxt = lnk_q;
          if (lnk_q != NIL) begin
            lnk_re    = 1'b1;
            lnk_raddr = IW'(lnk_q);
            rnk_re    = 1'b1;
            rnk_raddr = IW'(lnk_q);
            state_nxt = S_FR_DEC;
          end else begin
            state_nxt = S_FR_PUSH;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lnk_q;
          if (lnk_q != NIL) begin
            lnk_re    = 1'b1;
            lnk_raddr = IW'(lnk_q);
          end else begin
            state_nxt = S_FR_PUSH;
          end
        end
      end

      // renumber the slots behind the freed one, one per cycle
      S_FR_DEC: begin
        rnk_we    = 1'b1;
        rnk_waddr = IW'(cur_r);
        cur_nxt   = lnk_q;
        if (lnk_q != NIL) begin
          lnk_re    = 1'b1;
          lnk_raddr = IW'(lnk_q);
          rnk_re    = 1'b1;
          rnk_raddr = IW'(lnk_q);
        end else begin
          state_nxt = S_FR_PUSH;
        end
      end

      // append the freed slot to the free list
      S_FR_PUSH: begin
        lnk_we            = 1'b1;
        lnk_waddr         = s_idx;
        lnk_wdata         = NIL;
        in_use_nxt[s_idx] = 1'b0;
        if (live_r != '0) begin
          live_nxt = live_r - PW'(1);
        end
        if (fh_r == NIL) begin
          fh_nxt    = s_ptr;
          ft_nxt    = s_ptr;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FR_TAIL;
        end
      end

      // old free tail points to the freed slot
      S_FR_TAIL: begin
        lnk_we    = 1'b1;
        lnk_waddr = IW'(ft_r);
        lnk_wdata = s_ptr;
        ft_nxt    = s_ptr;
        state_nxt = S_DONE;
      end

      S_QR_WAIT: begin
        pos_nxt   = rnk_q;
        state_nxt = S_DONE;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r          <= stat_r;
      out_result_slot_r     <= rslot_r;
      out_position_number_r <= POS_W'(pos_r);
      out_active_count_r    <= POS_W'(live_r);
      out_first_valid_r     <= (ah_r != NIL);
      out_first_slot_r      <= (ah_r != NIL) ? SLOT_W'(ah_r) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_slot     = out_result_slot_r;
  assign out_position_number = out_position_number_r;
  assign out_active_count    = out_active_count_r;
  assign out_first_valid     = out_first_valid_r;
  assign out_first_slot      = out_first_slot_r;

endmodule

// ----- tb/osp_tb_pkg.sv -----
// result record and shadow model of the slot pool used by the testbench
package osp_tb_pkg;
  import osp_pkg::*;

  // spare command code, served by the block as a query
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // null link value in the shadow chains
  localparam logic [POS_W-1:0] SLOT_NIL = POS_W'(SLOTS_DEF);

  // one result as seen on the output channel
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] result_slot;
    logic [POS_W-1:0]  position_number;
    logic [POS_W-1:0]  active_count;
    logic              first_valid;
    logic [SLOT_W-1:0] first_slot;
  } pool_result_t;

  class pool_shadow;
    logic [POS_W-1:0] chain [SLOTS_DEF];
    logic [POS_W-1:0] rank  [SLOTS_DEF];
    bit               on_list [SLOTS_DEF];
    logic [POS_W-1:0] act_hd, act_tl, free_hd, free_tl, n_active;
    pool_result_t     awaited_results [$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        chain[i]   = POS_W'(i + 1);
        rank[i]    = '0;
        on_list[i] = 1'b0;
      end
      chain[SLOTS_DEF-1] = SLOT_NIL;
      act_hd   = SLOT_NIL;
      act_tl   = SLOT_NIL;
      free_hd  = '0;
      free_tl  = POS_W'(SLOTS_DEF - 1);
      n_active = '0;
      errors   = 0;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    // random slot from the active list, caller makes sure it is not empty
    function logic [SLOT_W-1:0] pick_active();
      logic [POS_W-1:0] cur;
      int hops;
      cur  = act_hd;
      hops = $urandom_range(0, int'(n_active) - 1);
      repeat (hops) cur = chain[cur];
      return cur[SLOT_W-1:0];
    endfunction

    // apply one accepted request to the shadow pool and queue its result
    function void note_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot);
      pool_result_t r;
      logic [POS_W-1:0] s, prv, cur;
      int guard;
      r.status          = STAT_OK;
      r.result_slot     = slot;
      r.position_number = '0;
      s = {1'b0, slot};
      if (cmd == CMD_ALLOC) begin
        r.result_slot = '0;
        if (free_hd == SLOT_NIL) begin
          r.status = STAT_FULL;
        end else begin
          // take free head, append to active tail
          s       = free_hd;
          free_hd = chain[s];
          if (free_hd == SLOT_NIL) free_tl = SLOT_NIL;
          chain[s] = SLOT_NIL;
          if (act_hd == SLOT_NIL) act_hd = s;
          else chain[act_tl] = s;
          act_tl     = s;
          on_list[s] = 1'b1;
          n_active   = n_active + 1'b1;
          rank[s]    = n_active;
          r.result_slot     = s[SLOT_W-1:0];
          r.position_number = n_active;
        end
      end else if (cmd == CMD_FREE) begin
        if (!on_list[s]) begin
          r.status = STAT_NOT_ACTIVE;
        end else begin
          // find predecessor and unlink
          prv   = SLOT_NIL;
          cur   = act_hd;
          guard = 0;
          while (cur != SLOT_NIL && cur != s && guard < SLOTS_DEF) begin
            prv = cur;
            cur = chain[cur];
            guard++;
          end
          if (prv == SLOT_NIL) act_hd = chain[s];
          else chain[prv] = chain[s];
          if (act_tl == s) act_tl = prv;
          // renumber the slots behind it
          cur   = chain[s];
          guard = 0;
          while (cur != SLOT_NIL && guard < SLOTS_DEF) begin
            if (rank[cur] != 0) rank[cur] = rank[cur] - 1'b1;
            cur = chain[cur];
            guard++;
          end
          on_list[s] = 1'b0;
          rank[s]    = '0;
          n_active   = n_active - 1'b1;
          // append to free tail, the free list may be empty
          chain[s] = SLOT_NIL;
          if (free_hd == SLOT_NIL) free_hd = s;
          else chain[free_tl] = s;
          free_tl = s;
        end
      end else begin
        r.position_number = rank[s];
      end
      r.active_count = n_active;
      r.first_valid  = (act_hd != SLOT_NIL);
      r.first_slot   = (act_hd != SLOT_NIL) ? act_hd[SLOT_W-1:0] : '0;
      awaited_results.push_back(r);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // compare one accepted result with the oldest queued one
    function void check_result(pool_result_t got);
      pool_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with no request pending: slot %0d status %0d",
                   got.result_slot, got.status);
        return;
      end
      want = awaited_results.pop_front();
      if (want.status != got.status) flag("status", want.status, got.status);
      if (want.result_slot != got.result_slot)
        flag("result_slot", want.result_slot, got.result_slot);
      if (want.position_number != got.position_number)
        flag("position_number", want.position_number, got.position_number);
      if (want.active_count != got.active_count)
        flag("active_count", want.active_count, got.active_count);
      if (want.first_valid != got.first_valid)
        flag("first_valid", want.first_valid, got.first_valid);
      if (want.first_slot != got.first_slot)
        flag("first_slot", want.first_slot, got.first_slot);
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// top level testbench of the ordered slot pool allocator
module tb_top;
  import osp_pkg::*;
  import osp_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_ITEMS = 21;
  localparam int RANDOM_ITEMS   = 1530;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_result_slot;
  logic [POS_W-1:0]  out_position_number;
  logic [POS_W-1:0]  out_active_count;
  logic              out_first_valid;
  logic [SLOT_W-1:0] out_first_slot;

  pool_shadow shadow;
  int         sent_count = 0;
  int         taken_count = 0;
  int         send_gap_max = 18;
  int         recv_stall_max = 18;

  ordered_slot_pool_allocator #(.SLOTS(SLOTS_DEF)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_slot             (in_slot),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_slot     (out_result_slot),
    .out_position_number (out_position_number),
    .out_active_count    (out_active_count),
    .out_first_valid     (out_first_valid),
    .out_first_slot      (out_first_slot)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // offer one request after a random gap and wait until it is taken
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_slot    <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_request(cmd, slot);
    sent_count++;
  endtask

  // one random request, weighted by the phase mix
  task automatic issue_random(input mix_t mix);
    int unsigned roll, alloc_pct, free_pct;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    case (mix)
      MIX_FILL: begin
        alloc_pct = 70;
        free_pct  = 15;
      end
      MIX_DRAIN: begin
        alloc_pct = 15;
        free_pct  = 70;
      end
      default: begin
        alloc_pct = 40;
        free_pct  = 40;
      end
    endcase
    roll = $urandom_range(0, 99);
    slot = SLOT_W'($urandom);
    if (roll < alloc_pct) begin
      cmd = CMD_ALLOC;
    end else if (roll < alloc_pct + free_pct) begin
      cmd = CMD_FREE;
      if (shadow.n_active != 0) slot = shadow.pick_active();
    end else begin
      // noise: blind frees, queries and the spare code
      case ($urandom_range(0, 2))
        0:       cmd = CMD_FREE;
        1:       cmd = CMD_QUERY;
        default: cmd = CMD_SPARE;
      endcase
    end
    send_request(cmd, slot);
  endtask

  // result side: random stall per result, one long hold-off
  initial begin
    int n;
    pool_result_t got;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = (taken_count == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, recv_stall_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status          = status_t'(out_status);
      got.result_slot     = out_result_slot;
      got.position_number = out_position_number;
      got.active_count    = out_active_count;
      got.first_valid     = out_first_valid;
      got.first_slot      = out_first_slot;
      shadow.check_result(got);
      taken_count++;
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // reset, directed requests, random phases, drain
  initial begin
    mix_t mix;
    int   len, phase;
    shadow = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pool: queries, frees of inactive slots, spare code
    send_request(CMD_QUERY, 5'd0);
    send_request(CMD_QUERY, 5'd31);
    send_request(CMD_FREE, 5'd0);
    send_request(CMD_FREE, 5'd31);
    send_request(CMD_SPARE, 5'd31);
    // five allocations give slots 0 to 4
    repeat (5) send_request(CMD_ALLOC, 5'd31);
    // free middle, head and tail, check renumbering
    send_request(CMD_QUERY, 5'd3);
    send_request(CMD_FREE, 5'd2);
    send_request(CMD_QUERY, 5'd3);
    send_request(CMD_FREE, 5'd0);
    send_request(CMD_FREE, 5'd4);
    send_request(CMD_QUERY, 5'd4);
    send_request(CMD_FREE, 5'd4);
    send_request(CMD_ALLOC, 5'd0);
    send_request(CMD_FREE, 5'd1);
    send_request(CMD_FREE, 5'd3);
    send_request(CMD_FREE, 5'd5);

    // random phases, first one fills the pool past full
    phase = 0;
    while (sent_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      mix = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      len = $urandom_range(60, 140);
      // last phase stops at the planned request count
      if (len > DIRECTED_ITEMS + RANDOM_ITEMS - sent_count) begin
        len = DIRECTED_ITEMS + RANDOM_ITEMS - sent_count;
      end
      case ($urandom_range(0, 3))
        0: begin
          send_gap_max   = 0;
          recv_stall_max = 0;
        end
        1: begin
          send_gap_max   = 0;
          recv_stall_max = 18;
        end
        2: begin
          send_gap_max   = 18;
          recv_stall_max = 0;
        end
        default: begin
          send_gap_max   = 18;
          recv_stall_max = 18;
        end
      endcase
      repeat (len) issue_random(mix);
      phase++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // wait for the last results, then a margin for stray ones
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
